>>> sv/lcc_pkg.sv
package lcc_pkg;

	// command codes on the input tuser
	localparam logic [1:0] CMD_INSTR  = 2'd0;
	localparam logic [1:0] CMD_DATA   = 2'd1;
	localparam logic [1:0] CMD_FLUSH  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// class codes, land in request bits 6..5
	localparam logic [1:0] CLS_INSTR = 2'b01;
	localparam logic [1:0] CLS_DATA  = 2'b10;

	localparam int FILL_W   = 3;
	localparam int RESULT_W = 40;

	typedef enum logic {
		OP_BYTE,
		OP_FLUSH
	} op_kind_t;

	typedef struct packed {
		logic [1:0] cls;
		logic [1:0] sel;
	} tag_t;

	typedef struct packed {
		op_kind_t   kind;
		logic       emit_en;
		tag_t       tag;
		logic [7:0] data;
	} op_t;

	typedef logic [3:0][7:0] held_bytes_t;

	// request byte: 0, class, targets, 0, count-1; then the two words
	function automatic logic [RESULT_W-1:0] make_result(tag_t tag, logic [FILL_W-1:0] cnt,
			held_bytes_t b);
		logic [1:0] cm1;
		logic [7:0] req;
		cm1 = 2'(cnt - 3'd1);
		req = {1'b0, tag.cls, tag.sel, 1'b0, cm1};
		return {b[3], b[2], b[1], b[0], req};
	endfunction

endpackage

>>> sv/lcc_front.sv
module lcc_front
	import lcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [3:0] s_tuser,
	input  logic [7:0] s_tdata,
	input  logic       q_full,
	output logic       push,
	output op_t        op
);

	logic [1:0] ctrl_map_q;
	logic [1:0] cmd;
	logic [1:0] sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_map_q <= '0;
		end else if (cfg_wr_en) begin
			ctrl_map_q <= cfg_wr_data;
		end
	end

	assign cmd      = s_tuser[1:0];
	assign sel      = s_tuser[3:2];
	assign s_tready = !q_full;
	// unused command is taken and dropped here
	assign push     = s_tvalid && !q_full && (cmd != CMD_UNUSED);

	always_comb begin
		op.kind    = (cmd == CMD_FLUSH) ? OP_FLUSH : OP_BYTE;
		op.emit_en = (ctrl_map_q != 2'b00);
		op.tag.cls = (cmd == CMD_INSTR) ? CLS_INSTR : CLS_DATA;
		op.tag.sel = sel & ctrl_map_q;
		op.data    = s_tdata;
	end

endmodule

>>> sv/lcc_queue.sv
module lcc_queue
	import lcc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output op_t  head_op,
	output logic empty,
	output logic full
);

	op_t        mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign empty   = (count_q == 2'd0);
	assign full    = (count_q == 2'd2);
	assign head_op = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue underflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");

endmodule

>>> sv/lcc_back.sv
module lcc_back
	import lcc_pkg::*;
#(
	parameter int GROUP_BYTES = 4
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  op_t                 head_op,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [RESULT_W-1:0] m_tdata
);

	held_bytes_t         bytes_q, bytes_d;
	tag_t                tag_q, tag_d;
	logic                valid_q, valid_d;
	logic [FILL_W-1:0]   fill_q, fill_d;
	logic                emit;
	logic [RESULT_W-1:0] res;
	logic                out_valid_q;
	logic [RESULT_W-1:0] out_data_q;

	// output register free or draining this cycle
	assign pop = !q_empty && (!out_valid_q || m_tready);

	always_comb begin
		bytes_d = bytes_q;
		tag_d   = tag_q;
		valid_d = valid_q;
		fill_d  = fill_q;
		emit    = 1'b0;
		res     = make_result(tag_q, fill_q, bytes_q);
		case (head_op.kind)
			OP_FLUSH: begin
				if (valid_q) begin
					emit    = head_op.emit_en;
					valid_d = 1'b0;
					fill_d  = '0;
				end
			end
			OP_BYTE: begin
				// type change: old group goes out first
				if (valid_q && (tag_q != head_op.tag)) begin
					emit   = head_op.emit_en;
					fill_d = '0;
				end
				bytes_d[fill_d[1:0]] = head_op.data;
				fill_d  = fill_d + 3'd1;
				tag_d   = head_op.tag;
				valid_d = 1'b1;
				if (fill_d >= FILL_W'(GROUP_BYTES)) begin
					emit    = head_op.emit_en;
					res     = make_result(tag_d, fill_d, bytes_d);
					valid_d = 1'b0;
					fill_d  = '0;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q     <= '0;
			tag_q       <= '0;
			valid_q     <= 1'b0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				bytes_q <= bytes_d;
				tag_q   <= tag_d;
				valid_q <= valid_d;
				fill_q  <= fill_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_data_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_fill_below_group: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < FILL_W'(GROUP_BYTES)) else $error("group left full");
	a_empty_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q |-> (fill_q == '0)) else $error("empty group with count");
	a_held_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (fill_q != '0)) else $error("held group with no bytes");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |=> (out_valid_q && $stable(out_data_q)))
		else $error("pending result overwritten");

endmodule

>>> sv/lcd_command_coalescer.sv
// LCD command coalescer
// Groups instruction/data bytes of one type into transfers of up to GROUP_BYTES
// bytes for one or two character-LCD controllers.
// Input stream (s_*): one word per command; tuser carries command and target
// select, tdata the byte. Command 3 is accepted and ignored.
// Output stream (m_*): one word per emitted transfer: request byte plus the
// four held bytes as two 16-bit words (stale bytes included).
// Config: cfg_wr_en/cfg_wr_data write the installed-controller map; write only
// while the block is idle. With a zero map groups are formed but never sent.
// Throughput: one input word per cycle, sustained, while m_tready stays high;
// the back end retires one queued op per cycle into the output register.
// Path: an accepted word is written into the two-entry queue; from the queue head
// the back end updates the held group and, when a transfer is emitted, the
// output register that drives m_tvalid.
// Stall: while a result is pending and m_tready is low the output register holds,
// the back end stops draining, and the two-entry queue fills before s_tready drops.
// Reset: map cleared, group emptied, held bytes zeroed, queue empty.
module lcd_command_coalescer
	import lcc_pkg::*;
#(
	parameter int GROUP_BYTES = 4
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_wr_data,   // controller map: bit0 ctrl 0, bit1 ctrl 1
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [3:0]  s_tuser,       // [1:0] command, [3:2] target_select
	input  logic [7:0]  s_tdata,       // [7:0] data_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata        // [7:0] request_byte, [23:8] value_word,
	                                   // [39:24] index_word
);

	logic push;
	logic pop;
	logic q_full;
	logic q_empty;
	op_t  push_op;
	op_t  head_op;

	// front: config register, command decode, type computation
	lcc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.q_full      (q_full),
		.push        (push),
		.op          (push_op)
	);

	lcc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.empty   (q_empty),
		.full    (q_full)
	);

	// back: held group, flush decisions, output register
	lcc_back #(
		.GROUP_BYTES (GROUP_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.head_op  (head_op),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
